// ----- rtl/core/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, types and helpers for the bitmap frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

	localparam int MAX_FRAMES = 4096;
	localparam int WORD_BITS  = 32;
	localparam int FRAME_W    = 12;
	localparam int CNT_W      = 13;

	localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W    = $clog2(WORD_COUNT);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int WCNT_W     = $clog2(WORD_COUNT + 1);
	localparam int FRAME_SPAN = 1 << FRAME_W;
	localparam int LIMIT_MAX  = (MAX_FRAMES < FRAME_SPAN) ? MAX_FRAMES : FRAME_SPAN;

	localparam logic [CNT_W-1:0] FC_RESET = CNT_W'(4096);

	// result status codes
	localparam logic [1:0] STAT_DONE   = 2'd0;
	localparam logic [1:0] STAT_NOP    = 2'd1;
	localparam logic [1:0] STAT_NOFREE = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_FREE_WR
	} ctrl_state_t;

	typedef enum logic [1:0] {
		RES_ECHO,
		RES_NOFREE,
		RES_ALLOC,
		RES_FREED
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     scan_init;
		logic     scan_step;
		logic     rd_free;
		logic     wr_alloc;
		logic     wr_free;
		logic     load;
		res_sel_t res_sel;
	} bfa_cmd_t;

	typedef struct packed {
		logic alloc;
		logic pf_zero;
		logic pf_out;
		logic no_words;
		logic hit;
		logic last;
	} bfa_flags_t;

	// lowest clear bit of a bitmap word
	function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bfa_ram.sv -----
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/bfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfa_ctrl
// Request sequencer: decides the request kind, runs the word scan or the
// read-modify-write of a free, and tells the datapath when to load a result.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ctrl
	import bfa_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire bfa_flags_t flags,
	output bfa_cmd_t        cmd,
	output logic            busy
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_sel = RES_ECHO;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (flags.alloc) begin
					if (!flags.pf_zero) begin
						cmd.load    = 1'b1;
						cmd.res_sel = RES_ECHO;
						state_d     = S_IDLE;
					end else if (flags.no_words) begin
						cmd.load    = 1'b1;
						cmd.res_sel = RES_NOFREE;
						state_d     = S_IDLE;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
				end else begin
					if (flags.pf_zero || flags.pf_out) begin
						cmd.load    = 1'b1;
						cmd.res_sel = RES_ECHO;
						state_d     = S_IDLE;
					end else begin
						cmd.rd_free = 1'b1;
						state_d     = S_FREE_WR;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (flags.hit) begin
					cmd.wr_alloc = 1'b1;
					cmd.load     = 1'b1;
					cmd.res_sel  = RES_ALLOC;
					state_d      = S_IDLE;
				end else if (flags.last) begin
					cmd.load    = 1'b1;
					cmd.res_sel = RES_NOFREE;
					state_d     = S_IDLE;
				end
			end
			S_FREE_WR: begin
				cmd.wr_free = 1'b1;
				cmd.load    = 1'b1;
				cmd.res_sel = RES_FREED;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	a_scan_ends_with_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && state_d == S_IDLE) |-> cmd.load)
		else $error("scan left without a result");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_alloc, cmd.wr_free, cmd.capture}))
		else $error("conflicting commands");

endmodule

`default_nettype wire

// ----- rtl/core/bfa_dp.sv -----
// ----------------------------------------------------------------------------
// bfa_dp
// Allocator datapath: request capture, frame limit register, bitmap RAM with
// per-word valid bits, first-free search and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_dp
	import bfa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bfa_cmd_t           cmd,
	output bfa_flags_t              flags,
	input  wire logic               func,
	input  wire logic [FRAME_W-1:0] page_frame,
	input  wire logic               kernel_only,
	input  wire logic               write_allowed,
	input  wire logic               cfg_we,
	input  wire logic [CNT_W-1:0]   cfg_data,
	output logic                    done,
	output logic [1:0]              status,
	output logic                    present,
	output logic                    writable,
	output logic                    user_access,
	output logic [FRAME_W-1:0]      frame_index
);

	logic                 func_q;
	logic [FRAME_W-1:0]   pf_q;
	logic                 kern_q;
	logic                 wrt_q;
	logic [CNT_W-1:0]     frame_count_q;
	logic [WCNT_W-1:0]    rd_ptr_q;
	logic                 chk_vld_q;
	logic [WADDR_W-1:0]   data_addr_q;
	logic [WORD_COUNT-1:0] valid_q;

	logic [CNT_W-1:0]     lim;
	logic [WCNT_W-1:0]    words;
	logic [WADDR_W-1:0]   rd_addr;
	logic [WADDR_W-1:0]   wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 we;
	logic [WORD_BITS-1:0] ram_rdata;
	logic [WORD_BITS-1:0] word_eff;
	logic                 word_full;
	logic [BIT_W-1:0]     zero_pos;
	logic [WORD_BITS-1:0] alloc_mask;
	logic [WORD_BITS-1:0] free_mask;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			pf_q   <= page_frame;
			kern_q <= kernel_only;
			wrt_q  <= write_allowed;
		end
		data_addr_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FC_RESET;
			rd_ptr_q      <= '0;
			chk_vld_q     <= 1'b0;
			valid_q       <= '0;
		end else begin
			if (cfg_we) begin
				frame_count_q <= cfg_data;
			end
			if (cmd.scan_init) begin
				rd_ptr_q  <= '0;
				chk_vld_q <= 1'b0;
			end else if (cmd.scan_step) begin
				rd_ptr_q  <= rd_ptr_q + WCNT_W'(1);
				chk_vld_q <= (rd_ptr_q < words);
			end
			if (we) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign lim   = (frame_count_q > CNT_W'(LIMIT_MAX)) ? CNT_W'(LIMIT_MAX) : frame_count_q;
	assign words = WCNT_W'(lim >> BIT_W);

	assign rd_addr = cmd.rd_free ? pf_q[FRAME_W-1:BIT_W] : rd_ptr_q[WADDR_W-1:0];

	bfa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_bitmap (
		.clk   (clk),
		.we    (we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// a word never written since reset reads as all free
	assign word_eff   = valid_q[data_addr_q] ? ram_rdata : '0;
	assign word_full  = &word_eff;
	assign zero_pos   = first_zero(word_eff);
	assign alloc_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << zero_pos;
	assign free_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << pf_q[BIT_W-1:0];

	assign we      = cmd.wr_alloc | cmd.wr_free;
	assign wr_addr = cmd.wr_free ? pf_q[FRAME_W-1:BIT_W] : data_addr_q;
	assign wr_data = cmd.wr_free ? (word_eff & ~free_mask) : (word_eff | alloc_mask);

	always_comb begin
		flags          = '0;
		flags.alloc    = !func_q;
		flags.pf_zero  = (pf_q == '0);
		flags.pf_out   = (CNT_W'(pf_q) >= lim);
		flags.no_words = (words == '0);
		flags.hit      = chk_vld_q && !word_full;
		flags.last     = chk_vld_q && word_full &&
			((WCNT_W'(data_addr_q) + WCNT_W'(1)) == words);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.load;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			unique case (cmd.res_sel)
				RES_ECHO: begin
					status      <= STAT_NOP;
					present     <= 1'b0;
					writable    <= 1'b0;
					user_access <= 1'b0;
					frame_index <= pf_q;
				end
				RES_NOFREE: begin
					status      <= STAT_NOFREE;
					present     <= 1'b0;
					writable    <= 1'b0;
					user_access <= 1'b0;
					frame_index <= '0;
				end
				RES_ALLOC: begin
					status      <= STAT_DONE;
					present     <= 1'b1;
					writable    <= wrt_q;
					user_access <= !kern_q;
					frame_index <= FRAME_W'({data_addr_q, zero_pos});
				end
				RES_FREED: begin
					status      <= STAT_DONE;
					present     <= 1'b0;
					writable    <= 1'b0;
					user_access <= 1'b0;
					frame_index <= '0;
				end
				default: begin
					status <= STAT_NOP;
				end
			endcase
		end
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_alloc_bit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_alloc |-> ((word_eff & alloc_mask) == '0))
		else $error("allocated a frame that is already used");

	a_alloc_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_alloc |=> (done && present && status == STAT_DONE))
		else $error("allocation write without a matching result");

	a_alloc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && present) |-> (CNT_W'(frame_index) < lim))
		else $error("allocated frame beyond the frame limit");

endmodule

`default_nettype wire

// ----- rtl/core/bitmap_frame_allocator.sv -----
// Every request passes a decide state, where a request with nothing to do
// ends; a free then rewrites one bitmap word, and an allocate primes the RAM
// read, then checks one bitmap word per cycle, up to 128 words. One request
// at a time: busy stays high until the result is loaded; the done strobe
// lasts one cycle and cannot be stalled. Reset marks every frame free at once
// through per-word valid bits and sets frame_count to 4096.
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit physical page frame allocator over a used/free bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_frame_allocator
	import bfa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               func,
	input  wire logic [FRAME_W-1:0] page_frame,
	input  wire logic               kernel_only,
	input  wire logic               write_allowed,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CNT_W-1:0]   cfg_data,
	output logic                    done,
	output logic [1:0]              status,
	output logic                    present,
	output logic                    writable,
	output logic                    user_access,
	output logic [FRAME_W-1:0]      frame_index
);

	bfa_cmd_t   cmd;
	bfa_flags_t flags;

	assign cfg_ready = !busy;

	bfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy)
	);

	bfa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.flags         (flags),
		.func          (func),
		.page_frame    (page_frame),
		.kernel_only   (kernel_only),
		.write_allowed (write_allowed),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.status        (status),
		.present       (present),
		.writable      (writable),
		.user_access   (user_access),
		.frame_index   (frame_index)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bitmap_frame_allocator. Requests go in through the
// start/busy handshake. A frame map model in the bench predicts each returned
// entry update, which is compared field by field as the done strobe arrives.
// frame_count is rewritten between phases, while the allocator is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bfa_pkg::*;

	localparam logic FUNC_ALLOC      = 1'b0;
	localparam logic FUNC_FREE       = 1'b1;
	localparam int   MAX_REPORTS     = 10;
	localparam int   IDLE_CYCLES     = 8;
	localparam int   DRAIN_CYCLES    = 140;
	localparam int   PHASES          = 10;
	localparam int   ITEMS_PER_PHASE = 160;

	typedef struct packed {
		logic [1:0]         status;
		logic               present;
		logic               writable;
		logic               user_access;
		logic [FRAME_W-1:0] frame;
	} entry_update_t;

	// Frame map model plus the queue of entry updates still owed by the DUT.
	class frame_map_checker;
		logic [WORD_BITS-1:0] used_map [WORD_COUNT];
		logic [CNT_W-1:0]     frame_count;
		entry_update_t        entry_updates_q[$];
		int                   errors;
		int                   reported;
		int                   checked;
		int                   stat_seen [3];

		function new();
			foreach (used_map[w]) used_map[w] = '0;
			foreach (stat_seen[s]) stat_seen[s] = 0;
			frame_count = FC_RESET;
			errors      = 0;
			reported    = 0;
			checked     = 0;
		endfunction

		function int frame_limit();
			return (int'(frame_count) > LIMIT_MAX) ? LIMIT_MAX : int'(frame_count);
		endfunction

		function void set_frame_count(logic [CNT_W-1:0] value);
			frame_count = value;
		endfunction

		function int pending();
			return entry_updates_q.size();
		endfunction

		// random frame in 1..limit-1 that is marked used, or -1 if none
		function int pick_used_frame();
			int lim;
			int base;
			int f;
			lim = frame_limit();
			if (lim < 2) return -1;
			base = $urandom_range(0, lim - 2);
			for (int k = 0; k < lim - 1; k++) begin
				f = 1 + (base + k) % (lim - 1);
				if (used_map[f / WORD_BITS][f % WORD_BITS]) return f;
			end
			return -1;
		endfunction

		function void note_request(logic fn, logic [FRAME_W-1:0] pf, logic kern,
				logic wrt);
			entry_update_t upd;
			int            lim;
			int            words;
			bit            found;
			upd   = '0;
			lim   = frame_limit();
			words = lim / WORD_BITS;
			found = 1'b0;
			if (fn == FUNC_ALLOC) begin
				if (pf != '0) begin
					upd.status = STAT_NOP;
					upd.frame  = pf;
				end else begin
					upd.status = STAT_NOFREE;
					// first fit: lowest word, then lowest bit; partial words are skipped
					for (int w = 0; w < words && !found; w++) begin
						for (int b = 0; b < WORD_BITS && !found; b++) begin
							if (!used_map[w][b]) begin
								used_map[w][b]  = 1'b1;
								upd.status      = STAT_DONE;
								upd.present     = 1'b1;
								upd.writable    = wrt;
								upd.user_access = ~kern;
								upd.frame       = FRAME_W'(w * WORD_BITS + b);
								found           = 1'b1;
							end
						end
					end
				end
			end else if (pf == '0 || int'(pf) >= lim) begin
				upd.status = STAT_NOP;
				upd.frame  = pf;
			end else begin
				used_map[pf / WORD_BITS][pf % WORD_BITS] = 1'b0;
				upd.status = STAT_DONE;
			end
			entry_updates_q.push_back(upd);
		endfunction

		function void check_entry(entry_update_t got);
			entry_update_t want;
			if (entry_updates_q.size() == 0) begin
				errors++;
				if (reported < MAX_REPORTS) begin
					reported++;
					$display("%0t: result with no request outstanding: status=%0d frame=%0d",
						$realtime, got.status, got.frame);
				end
				return;
			end
			want = entry_updates_q.pop_front();
			checked++;
			if (want.status <= STAT_NOFREE) stat_seen[want.status]++;
			if (got.status !== want.status || got.present !== want.present ||
					got.writable !== want.writable ||
					got.user_access !== want.user_access || got.frame !== want.frame) begin
				errors++;
				if (reported < MAX_REPORTS) begin
					reported++;
					$display("%0t: entry mismatch, expected st=%0d p=%0d w=%0d u=%0d frame=%0d",
						$realtime, want.status, want.present, want.writable,
						want.user_access, want.frame);
					$display("%0t:                 actual   st=%0d p=%0d w=%0d u=%0d frame=%0d",
						$realtime, got.status, got.present, got.writable,
						got.user_access, got.frame);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               func;
	logic [FRAME_W-1:0] page_frame;
	logic               kernel_only;
	logic               write_allowed;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data;
	logic               done;
	logic [1:0]         status;
	logic               present;
	logic               writable;
	logic               user_access;
	logic [FRAME_W-1:0] frame_index;

	frame_map_checker   fmap;
	entry_update_t      seen_entry;
	int                 items_sent;
	int                 cfg_writes;

	bitmap_frame_allocator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.page_frame    (page_frame),
		.kernel_only   (kernel_only),
		.write_allowed (write_allowed),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.status        (status),
		.present       (present),
		.writable      (writable),
		.user_access   (user_access),
		.frame_index   (frame_index)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// results cannot be stalled: take every done strobe at the edge ending it
	always @(posedge clk) begin
		if (arst_n && done) begin
			seen_entry.status      = status;
			seen_entry.present     = present;
			seen_entry.writable    = writable;
			seen_entry.user_access = user_access;
			seen_entry.frame       = frame_index;
			fmap.check_entry(seen_entry);
		end
	end

	// Called at a rising edge. start stays high after the transfer so that a
	// zero gap reuses it without a second assignment in the same step.
	task automatic send_request(input logic fn, input logic [FRAME_W-1:0] pf,
			input logic kern, input logic wrt, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		func          <= fn;
		page_frame    <= pf;
		kernel_only   <= kern;
		write_allowed <= wrt;
		do @(posedge clk); while (busy);
		fmap.note_request(fn, pf, kern, wrt);
		items_sent++;
	endtask

	task automatic wait_idle(input int extra);
		start <= 1'b0;
		while (fmap.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_frame_count(input logic [CNT_W-1:0] value);
		wait_idle(IDLE_CYCLES);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		fmap.set_frame_count(value);
		cfg_writes++;
	endtask

	task automatic run_directed();
		// reset count 4096: allocation starts at frame 0
		send_request(FUNC_ALLOC, 12'd0, 1'b0, 1'b1, 0);
		send_request(FUNC_ALLOC, 12'd0, 1'b1, 1'b0, 3);
		send_request(FUNC_ALLOC, 12'hFFF, 1'b1, 1'b1, 0);
		send_request(FUNC_ALLOC, 12'd1, 1'b0, 1'b0, 1);
		send_request(FUNC_FREE, 12'd0, 1'b1, 1'b1, 2);
		send_request(FUNC_FREE, 12'hFFF, 1'b1, 1'b1, 0);
		send_request(FUNC_FREE, 12'd1, 1'b0, 1'b0, 0);
		send_request(FUNC_FREE, 12'd1, 1'b0, 1'b1, 5);
		send_request(FUNC_ALLOC, 12'd0, 1'b1, 1'b1, 0);
		// count saturates at the 12-bit span
		write_frame_count(13'h1FFF);
		send_request(FUNC_FREE, 12'hFFF, 1'b0, 1'b0, 0);
		send_request(FUNC_ALLOC, 12'd0, 1'b0, 1'b0, 7);
		// under one word: nothing is searched, frees below the limit still work
		write_frame_count(13'd17);
		send_request(FUNC_ALLOC, 12'd0, 1'b0, 1'b1, 0);
		send_request(FUNC_FREE, 12'd16, 1'b0, 1'b0, 0);
		send_request(FUNC_FREE, 12'd17, 1'b0, 1'b0, 1);
		write_frame_count(13'd0);
		send_request(FUNC_ALLOC, 12'd0, 1'b1, 1'b0, 0);
		send_request(FUNC_FREE, 12'd5, 1'b1, 1'b1, 0);
		// one whole word plus a partial one
		write_frame_count(13'd33);
		send_request(FUNC_FREE, 12'd32, 1'b0, 1'b0, 0);
		send_request(FUNC_ALLOC, 12'd0, 1'b1, 1'b1, 0);
		write_frame_count(13'd4096);
		send_request(FUNC_ALLOC, 12'd0, 1'b1, 1'b1, 2);
	endtask

	// mostly allocations of unmapped entries and frees of used frames,
	// the rest mapped-entry allocations and frees of arbitrary frames
	task automatic run_random(input int count);
		int sel;
		int target;
		int gap_max;
		int gap;
		gap_max = 7;
		for (int n = 0; n < count; n++) begin
			if (n % 32 == 0) gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			gap    = $urandom_range(0, gap_max);
			sel    = $urandom_range(0, 99);
			target = fmap.pick_used_frame();
			if (sel < 50) begin
				send_request(FUNC_ALLOC, 12'd0, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), gap);
			end else if (sel < 80 && target > 0) begin
				send_request(FUNC_FREE, FRAME_W'(target), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), gap);
			end else if (sel < 90) begin
				send_request(FUNC_FREE, FRAME_W'($urandom_range(0, 4095)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gap);
			end else begin
				send_request(FUNC_ALLOC, FRAME_W'($urandom_range(1, 4095)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gap);
			end
		end
	endtask

	initial begin : main_seq
		int phase_counts [PHASES];
		int failures;
		phase_counts = '{4096, 32, 64, 8191, 100, 0, 4097, 17, 1000, 32};
		phase_counts[PHASES-1] = $urandom_range(32, 4096);
		fmap          = new();
		items_sent    = 0;
		cfg_writes    = 0;
		arst_n        <= 1'b0;
		start         <= 1'b0;
		func          <= FUNC_ALLOC;
		page_frame    <= '0;
		kernel_only   <= 1'b0;
		write_allowed <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		for (int p = 0; p < PHASES; p++) begin
			write_frame_count(CNT_W'(phase_counts[p]));
			run_random(ITEMS_PER_PHASE);
		end

		wait_idle(DRAIN_CYCLES);
		failures = fmap.errors + fmap.pending();
		$display("Sent %0d requests across %0d frame_count writes, %0d results checked",
			items_sent, cfg_writes, fmap.checked);
		$display("Status mix: %0d done, %0d nothing to do, %0d no free frame; %0d errors",
			fmap.stat_seen[STAT_DONE], fmap.stat_seen[STAT_NOP],
			fmap.stat_seen[STAT_NOFREE], failures);
		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/bfa_pkg.sv
rtl/core/bfa_ram.sv
rtl/core/bfa_ctrl.sv
rtl/core/bfa_dp.sv
rtl/core/bitmap_frame_allocator.sv
tb/tb_top.sv
